>>> design/falru_pkg.sv
// ----------------------------------------------------------------------------
// falru_pkg
// Shared types and sizes of the fully associative LRU tag engine.
// ----------------------------------------------------------------------------
`default_nettype none

package falru_pkg;

  localparam int ENTRIES     = 128;
  localparam int OFFSET_BITS = 4;
  localparam int TAG_BITS    = 12;
  localparam int ADDR_W      = 16;
  localparam int WAY_W       = $clog2(ENTRIES);
  localparam int IDX_W       = $clog2(ENTRIES + 1);
  localparam int CMP_W       = 8;
  localparam int AGE_W       = 32;
  localparam int CNT_W       = 32;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
  } falru_in_t;

  typedef struct packed {
    logic                hit;
    logic [WAY_W-1:0]    way;
    logic                replaced;
    logic [TAG_BITS-1:0] victim_tag;
    logic [CMP_W-1:0]    compares;
    logic [CNT_W-1:0]    hit_total;
    logic [CNT_W-1:0]    miss_total;
    logic [CNT_W-1:0]    compare_total;
  } falru_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic flush;
    logic scan;
    logic decide;
    logic update;
    logic emit;
  } falru_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pass_done;
  } falru_status_t;

endpackage

`default_nettype wire

>>> design/falru_ctrl.sv
// ----------------------------------------------------------------------------
// falru_ctrl
// Sequencer: lookup scan pass, decision, age update pass, result; or a flush.
// ----------------------------------------------------------------------------
`default_nettype none

module falru_ctrl import falru_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          kind,
  input  falru_status_t status,
  output falru_cmd_t    cmd,
  output logic          busy
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (kind) begin
            cmd.flush  = 1'b1;
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status.pass_done) begin
          cmd.decide = 1'b1;
          state_next = ST_UPDATE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_UPDATE: begin
        if (status.pass_done) begin
          state_next = ST_FINISH;
        end else begin
          cmd.update = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

>>> design/falru_dp.sv
// ----------------------------------------------------------------------------
// falru_dp
// Tag and age memories, valid bits, scan accumulators and running counters.
// ----------------------------------------------------------------------------
`default_nettype none

module falru_dp import falru_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  falru_cmd_t    cmd,
  input  falru_in_t     request,
  output falru_status_t status,
  output logic          done,
  output falru_out_t    result
);

  logic [ENTRIES-1:0]  valid;
  logic [TAG_BITS-1:0] tag_mem [ENTRIES];
  logic [AGE_W-1:0]    age_mem [ENTRIES];

  logic [IDX_W-1:0]    idx;
  logic [WAY_W-1:0]    rd_idx;
  logic                rd_vld;
  logic [TAG_BITS-1:0] tag_q;
  logic [AGE_W-1:0]    age_q;

  logic [TAG_BITS-1:0] req_tag;
  logic                found;
  logic                have_free;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_idx;
  logic [WAY_W-1:0]    best_idx;
  logic [AGE_W-1:0]    best_age;
  logic [TAG_BITS-1:0] best_tag;
  logic [CMP_W-1:0]    cmp;

  logic                hit_r;
  logic [WAY_W-1:0]    way_r;
  logic                replaced_r;
  logic [TAG_BITS-1:0] victim_r;

  logic [CNT_W-1:0]    hit_total;
  logic [CNT_W-1:0]    miss_total;
  logic [CNT_W-1:0]    compare_total;

  logic                idx_in_range;
  logic                rd_valid_bit;
  logic [WAY_W-1:0]    way_sel;
  logic                evict;

  function automatic logic [AGE_W-1:0] sat_inc(input logic [AGE_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  assign idx_in_range     = (idx < IDX_W'(ENTRIES));
  assign rd_valid_bit     = valid[rd_idx];
  assign status.pass_done = !idx_in_range && !rd_vld;
  assign evict            = !found && !have_free;
  assign way_sel          = found ? hit_way : (have_free ? free_idx : best_idx);

  // Tag memory: one read port for the scan and update passes, one write at the decision.
  always_ff @(posedge clk) begin
    if ((cmd.scan || cmd.update) && idx_in_range) begin
      tag_q <= tag_mem[idx[WAY_W-1:0]];
    end
    if (cmd.decide) begin
      tag_mem[way_sel] <= req_tag;
    end
  end

  // Age memory: read one entry ahead, write back the entry read last cycle.
  always_ff @(posedge clk) begin
    if ((cmd.scan || cmd.update) && idx_in_range) begin
      age_q <= age_mem[idx[WAY_W-1:0]];
    end
    if (cmd.update && rd_vld && ((rd_idx == way_r) || rd_valid_bit)) begin
      age_mem[rd_idx] <= (rd_idx == way_r) ? '0 : sat_inc(age_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      hit_total     <= '0;
      miss_total    <= '0;
      compare_total <= '0;
      done          <= 1'b0;
      rd_vld        <= 1'b0;
      idx           <= '0;
      found         <= 1'b0;
      have_free     <= 1'b0;
    end else begin
      done <= cmd.emit;

      if (cmd.load) begin
        req_tag    <= request.address[OFFSET_BITS +: TAG_BITS];
        idx        <= '0;
        rd_vld     <= 1'b0;
        found      <= 1'b0;
        have_free  <= 1'b0;
        cmp        <= '0;
        best_age   <= '0;
        best_idx   <= '0;
        best_tag   <= '0;
        hit_way    <= '0;
        free_idx   <= '0;
        hit_r      <= 1'b0;
        way_r      <= '0;
        replaced_r <= 1'b0;
        victim_r   <= '0;
      end

      if (cmd.flush) begin
        valid         <= '0;
        hit_total     <= '0;
        miss_total    <= '0;
        compare_total <= '0;
      end

      if (cmd.scan || cmd.update) begin
        rd_vld <= idx_in_range;
        rd_idx <= idx[WAY_W-1:0];
        if (idx_in_range) begin
          idx <= idx + 1'b1;
        end
      end

      // Scan pass: first match, compare count, first free entry, oldest entry.
      if (cmd.scan && rd_vld) begin
        if (rd_valid_bit && !found) begin
          cmp           <= cmp + 1'b1;
          compare_total <= sat_inc(compare_total);
          if (tag_q == req_tag) begin
            found   <= 1'b1;
            hit_way <= rd_idx;
          end
        end
        if (!rd_valid_bit && !have_free) begin
          have_free <= 1'b1;
          free_idx  <= rd_idx;
        end
        if (rd_valid_bit && (age_q > best_age)) begin
          best_age <= age_q;
          best_idx <= rd_idx;
          best_tag <= tag_q;
        end else if (rd_idx == '0) begin
          // Entry 0 is the victim when no entry has a nonzero age.
          best_tag <= tag_q;
        end
      end

      if (cmd.decide) begin
        hit_r          <= found;
        way_r          <= way_sel;
        replaced_r     <= evict;
        victim_r       <= evict ? best_tag : '0;
        valid[way_sel] <= 1'b1;
        idx            <= '0;
        rd_vld         <= 1'b0;
        if (found) begin
          hit_total <= sat_inc(hit_total);
        end else begin
          miss_total <= sat_inc(miss_total);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.hit           <= hit_r;
      result.way           <= way_r;
      result.replaced      <= replaced_r;
      result.victim_tag    <= victim_r;
      result.compares      <= cmp;
      result.hit_total     <= hit_total;
      result.miss_total    <= miss_total;
      result.compare_total <= compare_total;
    end
  end

endmodule

`default_nettype wire

>>> design/fully_assoc_lru_cache_tags.sv
// ----------------------------------------------------------------------------
// fully_assoc_lru_cache_tags
// Tag lookup and LRU replacement engine of a fully associative cache.
// ----------------------------------------------------------------------------
// An access makes two sequential passes over the 128-entry tag and age
//   memories (one port read per cycle): a lookup pass and an age update pass.
// A flush makes no pass. One item is in flight at a time; busy is high
//   until the cycle that shows the result, and the receiver cannot stall.
// Reset (rst, synchronous) clears all valid bits and the running counters.
// ----------------------------------------------------------------------------
`default_nettype none

module fully_assoc_lru_cache_tags import falru_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  falru_in_t  request,
  output logic       done,
  output falru_out_t result
);

  // The controller sequences each access through its passes; the datapath
  // holds the entries, walks them one per cycle and keeps the counters.
  falru_cmd_t    cmd;
  falru_status_t status;

  // A transfer happens when start is seen while the controller is idle.
  falru_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (request.kind),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The request is captured on the load command, so the caller may change
  // it after the transfer. The result register holds until the next item.
  falru_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .status  (status),
    .done    (done),
    .result  (result)
  );

endmodule

`default_nettype wire
